FILE: hw/rtl/mst_pkg.sv
// Shared types and constants for the min-tracking stack.
package mst_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int WORD_W = DATA_W + 2;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Default number of stack entries
    localparam int DEFAULT_DEPTH = 256;

    // Minimum register value after reset
    localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;

    // Operation codes (code 3 acts as a read)
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REFILL,
        S_EMIT
    } mst_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // execute the input transfer
        logic refill;    // load cached top from memory read data
        logic load_out;  // capture result into output register
    } mst_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_refill;  // offered item is a pop on a non-empty stack
    } mst_stat_t;

endpackage

FILE: hw/rtl/mst_datapath.sv
// Datapath of the min-tracking stack: entry memory, count, minimum, cached top, result.
module mst_datapath
    import mst_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mst_cmd_t               cmd,
    output mst_stat_t              stat,
    input  logic [DATA_W-1:0]      s_tdata,   // value
    input  logic [OP_W-1:0]        s_tuser,   // op
    output logic [2*DATA_W-1:0]    m_tdata,   // top_value, min_value
    output logic [STAT_W:0]        m_tuser    // is_empty, status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    // Entry memory, reset undefined
    logic [WORD_W-1:0]        mem [DEPTH];
    logic [WORD_W-1:0]        rd_data_reg;

    logic [CW-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [WORD_W-1:0] top_reg, top_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic [2*DATA_W-1:0]      out_data_reg;
    logic [STAT_W:0]          out_user_reg;

    logic signed [WORD_W-1:0] v_ext;
    logic signed [WORD_W-1:0] min_ext;
    logic signed [WORD_W-1:0] push_word;
    logic signed [WORD_W-1:0] restored;
    logic [CW-1:0]            count_m2;
    logic                     is_full;
    logic                     is_zero;
    logic                     do_push;
    logic                     do_pop;
    logic                     top_enc;
    logic signed [DATA_W-1:0] res_top;

    assign v_ext    = WORD_W'(signed'(s_tdata));
    assign min_ext  = WORD_W'(min_reg);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_zero  = (count_reg == '0);
    assign do_push  = (s_tuser == OP_PUSH) && !is_full;
    assign do_pop   = (s_tuser == OP_POP) && !is_zero;
    assign top_enc  = (top_reg < min_ext);
    assign restored = (min_ext <<< 1) - top_reg;
    assign count_m2 = count_reg - CW'(2);

    assign stat.pop_refill = do_pop;

    // Word to store for a push
    always_comb
    begin
        if (is_zero || v_ext >= min_ext)
        begin
            push_word = v_ext;
        end
        else
        begin
            push_word = (v_ext <<< 1) - min_ext;
        end
    end

    // Next state of count, minimum, cached top and status
    always_comb
    begin
        count_next  = count_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        status_next = status_reg;
        if (cmd.accept)
        begin
            status_next = STAT_OK;
            if (s_tuser == OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = STAT_PUSH_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    top_next   = push_word;
                    if (is_zero || v_ext < min_ext)
                    begin
                        min_next = signed'(s_tdata);
                    end
                end
            end
            else if (s_tuser == OP_POP)
            begin
                if (is_zero)
                begin
                    status_next = STAT_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (top_enc)
                    begin
                        min_next = restored[DATA_W-1:0];
                    end
                end
            end
        end
        else if (cmd.refill)
        begin
            top_next = signed'(rd_data_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= MIN_RESET;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        status_reg <= status_next;
    end

    // Memory: write on push, read entry below top on pop
    always_ff @(posedge clk)
    begin
        if (cmd.accept && do_push)
        begin
            mem[count_reg[AW-1:0]] <= push_word;
        end
        rd_data_reg <= mem[count_m2[AW-1:0]];
    end

    // Decoded top
    assign res_top = top_enc ? min_reg : top_reg[DATA_W-1:0];

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (is_zero)
            begin
                out_data_reg <= '0;
                out_user_reg <= {status_reg, 1'b1};
            end
            else
            begin
                out_data_reg <= {min_reg, res_top};
                out_user_reg <= {status_reg, 1'b0};
            end
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

FILE: hw/rtl/mst_ctrl.sv
// Controller of the min-tracking stack: item sequencing and output valid.
module mst_ctrl
    import mst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  mst_stat_t stat,
    output mst_cmd_t  cmd
);

    mst_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // State register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.pop_refill ? S_REFILL : S_EMIT;
                end
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb
    begin
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: hw/rtl/min_tracking_stack_top.sv
// Top level of the min-tracking stack.
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+------------------------------
//  s_*      | in        | [31:0] value                   | [1:0] op
//  m_*      | out       | [31:0] top_value, [63:32] min  | [0] is_empty, [2:1] status
//
// Push and read execute, then load the output register; a pop refills the cached
// top in between, since it comes back from the synchronous entry memory read.
// Reset clears the entry count and sets the minimum to the largest value; the
// memory is not cleared. A held result stalls only the load of the next result,
// and the next item is taken while the previous one waits in the output register.
module min_tracking_stack_top
    import mst_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*DATA_W-1:0] m_tdata,   // [31:0] top_value, [63:32] min_value
    output logic [STAT_W:0]     m_tuser    // [0] is_empty, [2:1] status
);

    mst_cmd_t  cmd;
    mst_stat_t stat;

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mst_datapath #(
        .DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: hw/rtl/mst_checker.sv
// Port-level checks for the min-tracking stack, bound to the top level.
module mst_checker
    import mst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [2*DATA_W-1:0] m_tdata,
    input logic [STAT_W:0]     m_tuser
);

    // One item in flight: no transfer in the cycle after an input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken back to back");

    // Empty result reads zero top and minimum
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty result with nonzero data");

    // Status code is always defined
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:1] != 2'd3))
        else $error("undefined status code");

    // Ignored pop leaves the stack empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:1] == STAT_POP_EMPTY) |-> m_tuser[0])
        else $error("pop on empty with non-empty result");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind min_tracking_stack_top mst_checker u_mst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/min_tracking_stack_top_tb.sv
// Self-checking testbench for the min-tracking stack top level.
module min_tracking_stack_top_tb;
    import mst_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    // Unused op code; the block handles it as a read
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // Cycles with no transfer on either side before the run is abandoned
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    // One result view: decoded top, minimum, empty flag, status
    typedef struct packed {
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] minv;
        logic                     empty;
        logic [STAT_W-1:0]        status;
    } stack_view_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [31:0] value
    logic [OP_W-1:0]     s_tuser;   // [1:0] op
    logic                m_tvalid;
    logic                m_tready;
    logic [2*DATA_W-1:0] m_tdata;   // [31:0] top_value, [63:32] min_value
    logic [STAT_W:0]     m_tuser;   // [0] is_empty, [2:1] status

    // Shadow copy of the stack contents
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int unsigned              shadow_count;
    logic signed [DATA_W-1:0] shadow_min;

    stack_view_t stack_view_q [$];
    int          mismatches;
    bit          send_quiet;
    bit          recv_quiet;

    min_tracking_stack_top #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one operation to the shadow stack and return the view it yields
    function automatic stack_view_t apply_stack_op(logic [OP_W-1:0] op,
                                                   logic signed [DATA_W-1:0] v);
        stack_view_t              r;
        logic signed [WORD_W-1:0] vw;
        logic signed [WORD_W-1:0] mw;
        logic signed [WORD_W-1:0] w;
        logic signed [WORD_W-1:0] restored;
        r.status = STAT_OK;
        vw = {{2{v[DATA_W-1]}}, v};
        mw = {{2{shadow_min[DATA_W-1]}}, shadow_min};
        if (op == OP_PUSH)
        begin
            if (shadow_count >= DEPTH)
                r.status = STAT_PUSH_FULL;
            else if (shadow_count == 0)
            begin
                shadow_words[0] = vw;
                shadow_min = v;
                shadow_count = 1;
            end
            else if (vw >= mw)
            begin
                shadow_words[shadow_count] = vw;
                shadow_count++;
            end
            else
            begin
                // new minimum: store the encoded difference
                shadow_words[shadow_count] = 2 * vw - mw;
                shadow_min = v;
                shadow_count++;
            end
        end
        else if (op == OP_POP)
        begin
            if (shadow_count == 0)
                r.status = STAT_POP_EMPTY;
            else
            begin
                w = shadow_words[shadow_count - 1];
                if (w < mw)
                begin
                    restored = 2 * mw - w;
                    shadow_min = restored[DATA_W-1:0];
                end
                shadow_count--;
            end
        end
        // Report view after the operation
        if (shadow_count == 0)
        begin
            r.top = '0;
            r.minv = '0;
            r.empty = 1'b1;
        end
        else
        begin
            mw = {{2{shadow_min[DATA_W-1]}}, shadow_min};
            w = shadow_words[shadow_count - 1];
            r.top = (w < mw) ? shadow_min : w[DATA_W-1:0];
            r.minv = shadow_min;
            r.empty = 1'b0;
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 15);
        if (quiet || r < 8)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Value to push: extremes, values near the running minimum, or anything
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
        begin
            case ($urandom_range(0, 3))
                0: return INT_MIN;
                1: return INT_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 6)
            return shadow_min + $urandom_range(0, 6) - 3;
        return $urandom;
    endfunction

    // Send one transfer, record its expected view, then idle
    task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] v);
        int gap;
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = v;
        do
            @(posedge clk);
        while (!s_tready);
        stack_view_q.push_back(apply_stack_op(op, v));
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata = $urandom;
        s_tuser = OP_W'($urandom);
        gap = pick_gap(send_quiet);
        repeat (gap) @(negedge clk);
    endtask

    // Hold the sender until every expected view has come back
    task automatic wait_results_drained();
        while (stack_view_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Corner cases on an empty and a shallow stack
    task automatic test_corner_cases();
        send_item(OP_READ, $urandom);
        send_item(OP_POP, $urandom);
        send_item(OP_SPARE, $urandom);
        send_item(OP_PUSH, INT_MAX);
        send_item(OP_PUSH, INT_MIN);    // widest encoded word
        send_item(OP_READ, '0);
        send_item(OP_PUSH, INT_MIN);    // equal to minimum, stored plain
        send_item(OP_PUSH, 32'sd5);
        send_item(OP_SPARE, '1);
        send_item(OP_POP, '1);
        send_item(OP_POP, '0);
        send_item(OP_POP, '1);          // encoded entry restores the maximum
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_PUSH, -32'sd5);
        send_item(OP_POP, '0);
        // minimum register still holds -5; push on empty must overwrite it
        send_item(OP_PUSH, 32'sd100);
        send_item(OP_PUSH, 32'sd99);
        send_item(OP_PUSH, 32'sd100);
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_READ, '1);
        send_item(OP_POP, '0);
        send_item(OP_READ, '0);
    endtask

    // Fill to capacity, push on full, then empty the stack again
    task automatic test_full_stack();
        while (shadow_count < DEPTH)
            send_item(OP_PUSH, ($urandom_range(0, 3) == 0) ? pick_value() : $urandom);
        send_item(OP_PUSH, INT_MIN);
        send_item(OP_PUSH, INT_MAX);
        send_item(OP_PUSH, $urandom);
        send_item(OP_READ, $urandom);
        send_item(OP_SPARE, $urandom);
        wait_results_drained();
        while (shadow_count > 0)
            send_item(OP_POP, $urandom);
        send_item(OP_POP, $urandom);
        send_item(OP_POP, $urandom);
    endtask

    // Random operation mix in blocks with varying push bias and idle modes
    task automatic test_random_ops();
        int               push_pct;
        int               r;
        logic [OP_W-1:0]  op;
        for (int blk = 0; blk < 8; blk++)
        begin
            push_pct = $urandom_range(30, 75);
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if (blk % 5 == 4)
                wait_results_drained();
            for (int i = 0; i < 32; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    op = OP_PUSH;
                else if (r < 85)
                    op = OP_POP;
                else if (r < 97)
                    op = OP_READ;
                else
                    op = OP_SPARE;
                send_item(op, pick_value());
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    // Receiver: random stalls on the result side
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap(recv_quiet);
            end
        end
    end

    // Result checker
    initial
    begin
        stack_view_t got;
        stack_view_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.top = m_tdata[DATA_W-1:0];
                got.minv = m_tdata[2*DATA_W-1:DATA_W];
                got.empty = m_tuser[0];
                got.status = m_tuser[STAT_W:1];
                if (stack_view_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: top %0d min %0d empty %0b status %0d",
                                 got.top, got.minv, got.empty, got.status);
                    mismatches++;
                end
                else
                begin
                    want = stack_view_q.pop_front();
                    if (got.top !== want.top || got.minv !== want.minv
                        || got.empty !== want.empty || got.status !== want.status)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected top %0d min %0d empty %0b status %0d,",
                                      " got top %0d min %0d empty %0b status %0d"},
                                     want.top, want.minv, want.empty, want.status,
                                     got.top, got.minv, got.empty, got.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: no transfer on either side for too long
    initial
    begin
        int stuck;
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        shadow_count = 0;
        shadow_min = MIN_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        wait_results_drained();
        test_full_stack();
        test_random_ops();

        // Let the last results drain, then a short tail for stray transfers
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && stack_view_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
